// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the framer RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HMF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("framer check failed");
`define HMF_ASSERT_NEVER(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) \
        else $error("framer forbidden condition");
`else
`define HMF_ASSERT(lbl, clk, rstn, prop)
`define HMF_ASSERT_NEVER(lbl, clk, rstn, prop)
`endif
`endif

// ----- hw/rtl/hmf_pkg.sv -----
// Package for the HTTP message framer: types, codes and character tables.
// Used by every RTL module of the framer; depends on nothing.
`timescale 1ns / 1ps
package hmf_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int NUM_W = LENGTH_BITS;
    localparam int REM_W = LENGTH_BITS + 2;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_SP = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [23:0] TERM_PREFIX = 24'h0D0A0D;

    localparam logic [7:0] CFG_IS_RESPONSE = 8'd0;
    localparam logic [7:0] CFG_HEADER_CAP = 8'd1;
    localparam logic [7:0] CFG_CHUNK_CAP = 8'd2;
    localparam logic [7:0] CFG_TRAILER_CAP = 8'd3;

    localparam logic [2:0] CLS_HEADER = 3'd0;
    localparam logic [2:0] CLS_LENGTH = 3'd1;
    localparam logic [2:0] CLS_CHUNK_LINE = 3'd2;
    localparam logic [2:0] CLS_CHUNK_DATA = 3'd3;
    localparam logic [2:0] CLS_TRAILER = 3'd4;
    localparam logic [2:0] CLS_CLOSE = 3'd5;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_LENGTH = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;
    localparam logic [1:0] MODE_CLOSE = 2'd3;

    localparam logic [2:0] ERR_NONE = 3'd0;
    localparam logic [2:0] ERR_HEADER_LONG = 3'd1;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd2;
    localparam logic [2:0] ERR_CONFLICT = 3'd3;
    localparam logic [2:0] ERR_CHUNK_LONG = 3'd4;
    localparam logic [2:0] ERR_BAD_CHUNK = 3'd5;
    localparam logic [2:0] ERR_CHUNK_OVF = 3'd6;
    localparam logic [2:0] ERR_TRAILER_LONG = 3'd7;

    localparam logic [4:0] CL_NAME_LEN = 5'd15;
    localparam logic [4:0] TE_NAME_LEN = 5'd18;
    localparam logic [2:0] CK_WORD_LEN = 3'd7;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_LENGTH = 6'b000010,
        PH_CHUNK_LINE = 6'b000100,
        PH_CHUNK_DATA = 6'b001000,
        PH_TRAILER = 6'b010000,
        PH_CLOSE = 6'b100000
    } phase_t;

    typedef enum logic [5:0] {
        K_START = 6'b000001,
        K_MATCH_CL = 6'b000010,
        K_MATCH_TE = 6'b000100,
        K_VAL_CL = 6'b001000,
        K_VAL_TE = 6'b010000,
        K_SKIP = 6'b100000
    } line_kind_t;

    typedef enum logic [3:0] {
        V_LEAD = 4'b0001,
        V_DIGITS = 4'b0010,
        V_TRAIL = 4'b0100,
        V_BAD = 4'b1000
    } value_stage_t;

    typedef struct packed {
        logic        is_response;
        logic [15:0] header_byte_cap;
        logic [11:0] chunk_line_cap;
        logic [11:0] trailer_line_cap;
    } cfg_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] byte_class;
        logic       header_done;
        logic [1:0] body_mode;
        logic       message_end;
        logic [2:0] error_code;
    } result_t;

    function automatic logic [2:0] phase_class(input phase_t ph);
        logic [2:0] cls;
        unique case (ph)
            PH_HEADER: cls = CLS_HEADER;
            PH_LENGTH: cls = CLS_LENGTH;
            PH_CHUNK_LINE: cls = CLS_CHUNK_LINE;
            PH_CHUNK_DATA: cls = CLS_CHUNK_DATA;
            PH_TRAILER: cls = CLS_TRAILER;
            PH_CLOSE: cls = CLS_CLOSE;
            default: cls = CLS_HEADER;
        endcase
        return cls;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'd32 : b;
    endfunction

    function automatic logic [7:0] cl_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0: c = "c";
            5'd1: c = "o";
            5'd2: c = "n";
            5'd3: c = "t";
            5'd4: c = "e";
            5'd5: c = "n";
            5'd6: c = "t";
            5'd7: c = "-";
            5'd8: c = "l";
            5'd9: c = "e";
            5'd10: c = "n";
            5'd11: c = "g";
            5'd12: c = "t";
            5'd13: c = "h";
            5'd14: c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] te_char(input logic [4:0] pos);
        logic [7:0] c;
        case (pos)
            5'd0: c = "t";
            5'd1: c = "r";
            5'd2: c = "a";
            5'd3: c = "n";
            5'd4: c = "s";
            5'd5: c = "f";
            5'd6: c = "e";
            5'd7: c = "r";
            5'd8: c = "-";
            5'd9: c = "e";
            5'd10: c = "n";
            5'd11: c = "c";
            5'd12: c = "o";
            5'd13: c = "d";
            5'd14: c = "i";
            5'd15: c = "n";
            5'd16: c = "g";
            5'd17: c = ":";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] ck_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0: c = "c";
            3'd1: c = "h";
            3'd2: c = "u";
            3'd3: c = "n";
            3'd4: c = "k";
            3'd5: c = "e";
            3'd6: c = "d";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Returns {valid, value} for a hexadecimal digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [7:0] l;
        l = to_lower(b);
        if (b >= "0" && b <= "9") begin
            return {1'b1, b[3:0]};
        end
        if (l >= "a" && l <= "f") begin
            return {1'b1, 4'(l - 8'h57)};
        end
        return 5'd0;
    endfunction

endpackage

// ----- hw/rtl/hmf_cfg_regs.sv -----
// Configuration register file of the HTTP message framer.
// Depends on hmf_pkg.
`timescale 1ns / 1ps
module hmf_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [7:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output hmf_pkg::cfg_t cfg
);

    hmf_pkg::cfg_t cfg_reg;
    hmf_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                hmf_pkg::CFG_IS_RESPONSE: cfg_next.is_response = cfg_data[0];
                hmf_pkg::CFG_HEADER_CAP: cfg_next.header_byte_cap = cfg_data;
                hmf_pkg::CFG_CHUNK_CAP: cfg_next.chunk_line_cap = cfg_data[11:0];
                hmf_pkg::CFG_TRAILER_CAP: cfg_next.trailer_line_cap = cfg_data[11:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.is_response <= 1'b0;
            cfg_reg.header_byte_cap <= 16'd8192;
            cfg_reg.chunk_line_cap <= 12'd256;
            cfg_reg.trailer_line_cap <= 12'd1024;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hw/rtl/hmf_parser.sv -----
// Parser state and per-byte update logic of the HTTP message framer.
// Depends on hmf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hmf_parser (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic [7:0]       data_byte,
    input  hmf_pkg::cfg_t    cfg,
    output hmf_pkg::result_t res
);

    localparam int NW = hmf_pkg::NUM_W;
    localparam int RW = hmf_pkg::REM_W;

    hmf_pkg::phase_t phase_reg, phase_next;
    logic [15:0] header_count_reg, header_count_next;
    logic [11:0] line_count_reg, line_count_next;
    logic [23:0] recent_bytes_reg, recent_bytes_next;
    logic first_line_reg, first_line_next;
    hmf_pkg::line_kind_t line_kind_reg, line_kind_next;
    logic [4:0] name_match_pos_reg, name_match_pos_next;
    hmf_pkg::value_stage_t value_stage_reg, value_stage_next;
    logic [NW-1:0] number_acc_reg, number_acc_next;
    logic [NW-1:0] length_value_reg, length_value_next;
    logic have_length_reg, have_length_next;
    logic chunked_flag_reg, chunked_flag_next;
    logic [2:0] chunked_match_pos_reg, chunked_match_pos_next;
    logic [9:0] status_acc_reg, status_acc_next;
    logic [1:0] status_stage_reg, status_stage_next;
    logic size_overflow_reg, size_overflow_next;
    logic [RW-1:0] remaining_reg, remaining_next;
    logic [2:0] sticky_error_reg, sticky_error_next;

    logic [7:0] prev;
    logic [7:0] low_b;
    logic is_digit, is_blank, crlf, term, forbids, clear_hdr;
    logic [3:0] digit;
    logic [4:0] hex;
    logic [NW+3:0] dec_prod;
    logic [NW-1:0] dec_base;
    logic [13:0] status_prod;
    hmf_pkg::value_stage_t vs_tmp;
    logic hd, fin;
    logic [1:0] mode;
    logic [2:0] err;

    assign prev = recent_bytes_reg[7:0];
    assign low_b = hmf_pkg::to_lower(data_byte);
    assign is_digit = data_byte >= "0" && data_byte <= "9";
    assign digit = data_byte[3:0];
    assign is_blank = data_byte == hmf_pkg::CH_SP || data_byte == hmf_pkg::CH_TAB;
    assign hex = hmf_pkg::hex_digit(data_byte);
    assign crlf = data_byte == hmf_pkg::CH_LF && prev == hmf_pkg::CH_CR;
    assign term = crlf && recent_bytes_reg == hmf_pkg::TERM_PREFIX;
    assign forbids = cfg.is_response
        && ((status_acc_reg >= 10'd100 && status_acc_reg < 10'd200)
            || status_acc_reg == 10'd204 || status_acc_reg == 10'd304);
    assign dec_base = (value_stage_reg == hmf_pkg::V_LEAD) ? '0 : number_acc_reg;
    assign dec_prod = ({4'd0, dec_base} << 3) + ({4'd0, dec_base} << 1)
        + {{NW{1'b0}}, digit};
    assign status_prod = ({4'd0, status_acc_reg} << 3) + ({4'd0, status_acc_reg} << 1)
        + {10'd0, digit};

    always_comb
    begin
        phase_next = phase_reg;
        header_count_next = header_count_reg;
        line_count_next = line_count_reg;
        recent_bytes_next = recent_bytes_reg;
        first_line_next = first_line_reg;
        line_kind_next = line_kind_reg;
        name_match_pos_next = name_match_pos_reg;
        value_stage_next = value_stage_reg;
        number_acc_next = number_acc_reg;
        length_value_next = length_value_reg;
        have_length_next = have_length_reg;
        chunked_flag_next = chunked_flag_reg;
        chunked_match_pos_next = chunked_match_pos_reg;
        status_acc_next = status_acc_reg;
        status_stage_next = status_stage_reg;
        size_overflow_next = size_overflow_reg;
        remaining_next = remaining_reg;
        sticky_error_next = sticky_error_reg;
        hd = 1'b0;
        fin = 1'b0;
        mode = hmf_pkg::MODE_NONE;
        err = hmf_pkg::ERR_NONE;
        clear_hdr = 1'b0;
        vs_tmp = value_stage_reg;

        if (sticky_error_reg != hmf_pkg::ERR_NONE)
        begin
            err = sticky_error_reg;
        end
        else
        begin
            unique case (phase_reg)
                hmf_pkg::PH_HEADER:
                begin
                    if (header_count_reg >= cfg.header_byte_cap)
                    begin
                        err = hmf_pkg::ERR_HEADER_LONG;
                    end
                    else if (!crlf)
                    begin
                        header_count_next = header_count_reg + 16'd1;
                        if (first_line_reg)
                        begin
                            case (status_stage_reg)
                                2'd0:
                                begin
                                    if (data_byte == hmf_pkg::CH_SP)
                                    begin
                                        status_stage_next = 2'd1;
                                    end
                                end
                                2'd1:
                                begin
                                    if (is_digit)
                                    begin
                                        status_acc_next = {6'd0, digit};
                                        status_stage_next = 2'd2;
                                    end
                                    else if (!is_blank)
                                    begin
                                        status_acc_next = 10'd0;
                                        status_stage_next = 2'd3;
                                    end
                                end
                                2'd2:
                                begin
                                    if (is_digit)
                                    begin
                                        status_acc_next = (status_prod > 14'd999) ? 10'd1000
                                            : status_prod[9:0];
                                    end
                                    else
                                    begin
                                        status_stage_next = 2'd3;
                                    end
                                end
                                default:
                                begin
                                    status_stage_next = status_stage_reg;
                                end
                            endcase
                        end
                        unique case (line_kind_reg)
                            hmf_pkg::K_START:
                            begin
                                if (low_b == "c")
                                begin
                                    line_kind_next = hmf_pkg::K_MATCH_CL;
                                    name_match_pos_next = 5'd1;
                                end
                                else if (low_b == "t")
                                begin
                                    line_kind_next = hmf_pkg::K_MATCH_TE;
                                    name_match_pos_next = 5'd1;
                                end
                                else
                                begin
                                    line_kind_next = hmf_pkg::K_SKIP;
                                end
                            end
                            hmf_pkg::K_MATCH_CL:
                            begin
                                if (name_match_pos_reg < hmf_pkg::CL_NAME_LEN
                                    && low_b == hmf_pkg::cl_char(name_match_pos_reg))
                                begin
                                    name_match_pos_next = name_match_pos_reg + 5'd1;
                                    if (name_match_pos_next == hmf_pkg::CL_NAME_LEN)
                                    begin
                                        line_kind_next = hmf_pkg::K_VAL_CL;
                                        value_stage_next = hmf_pkg::V_LEAD;
                                        number_acc_next = '0;
                                    end
                                end
                                else
                                begin
                                    line_kind_next = hmf_pkg::K_SKIP;
                                end
                            end
                            hmf_pkg::K_MATCH_TE:
                            begin
                                if (name_match_pos_reg < hmf_pkg::TE_NAME_LEN
                                    && low_b == hmf_pkg::te_char(name_match_pos_reg))
                                begin
                                    name_match_pos_next = name_match_pos_reg + 5'd1;
                                    if (name_match_pos_next == hmf_pkg::TE_NAME_LEN)
                                    begin
                                        line_kind_next = hmf_pkg::K_VAL_TE;
                                        chunked_match_pos_next = 3'd0;
                                    end
                                end
                                else
                                begin
                                    line_kind_next = hmf_pkg::K_SKIP;
                                end
                            end
                            hmf_pkg::K_VAL_CL:
                            begin
                                if (prev == hmf_pkg::CH_CR)
                                begin
                                    vs_tmp = hmf_pkg::V_BAD;
                                end
                                value_stage_next = vs_tmp;
                                if (data_byte == hmf_pkg::CH_CR || vs_tmp == hmf_pkg::V_BAD)
                                begin
                                    value_stage_next = vs_tmp;
                                end
                                else if (is_digit && vs_tmp != hmf_pkg::V_TRAIL)
                                begin
                                    if (dec_prod[NW+3:NW] != 4'd0)
                                    begin
                                        number_acc_next = dec_base;
                                        value_stage_next = hmf_pkg::V_BAD;
                                    end
                                    else
                                    begin
                                        number_acc_next = dec_prod[NW-1:0];
                                        value_stage_next = hmf_pkg::V_DIGITS;
                                    end
                                end
                                else if (is_blank)
                                begin
                                    if (vs_tmp == hmf_pkg::V_DIGITS)
                                    begin
                                        value_stage_next = hmf_pkg::V_TRAIL;
                                    end
                                end
                                else
                                begin
                                    value_stage_next = hmf_pkg::V_BAD;
                                end
                            end
                            hmf_pkg::K_VAL_TE:
                            begin
                                if (chunked_match_pos_reg < hmf_pkg::CK_WORD_LEN)
                                begin
                                    if (low_b == hmf_pkg::ck_char(chunked_match_pos_reg))
                                    begin
                                        chunked_match_pos_next = chunked_match_pos_reg + 3'd1;
                                    end
                                    else
                                    begin
                                        chunked_match_pos_next = (low_b == "c") ? 3'd1 : 3'd0;
                                    end
                                end
                            end
                            default:
                            begin
                                line_kind_next = line_kind_reg;
                            end
                        endcase
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 16'd1;
                        if (line_kind_reg == hmf_pkg::K_VAL_CL)
                        begin
                            if (value_stage_reg == hmf_pkg::V_LEAD
                                || value_stage_reg == hmf_pkg::V_BAD)
                            begin
                                err = hmf_pkg::ERR_BAD_LENGTH;
                            end
                            else if (have_length_reg && number_acc_reg != length_value_reg)
                            begin
                                err = hmf_pkg::ERR_CONFLICT;
                            end
                            else
                            begin
                                length_value_next = number_acc_reg;
                                have_length_next = 1'b1;
                            end
                        end
                        else if (line_kind_reg == hmf_pkg::K_VAL_TE)
                        begin
                            chunked_flag_next = chunked_match_pos_reg == hmf_pkg::CK_WORD_LEN;
                        end
                        line_kind_next = hmf_pkg::K_START;
                        name_match_pos_next = 5'd0;
                        first_line_next = 1'b0;
                        value_stage_next = hmf_pkg::V_LEAD;
                        number_acc_next = '0;
                        if (term)
                        begin
                            hd = 1'b1;
                            clear_hdr = 1'b1;
                            if (forbids)
                            begin
                                fin = 1'b1;
                            end
                            else if (chunked_flag_next)
                            begin
                                mode = hmf_pkg::MODE_CHUNKED;
                                phase_next = hmf_pkg::PH_CHUNK_LINE;
                            end
                            else if (have_length_next && length_value_next != '0)
                            begin
                                mode = hmf_pkg::MODE_LENGTH;
                                phase_next = hmf_pkg::PH_LENGTH;
                                remaining_next = {2'd0, length_value_next};
                            end
                            else if (cfg.is_response && !have_length_next)
                            begin
                                mode = hmf_pkg::MODE_CLOSE;
                                phase_next = hmf_pkg::PH_CLOSE;
                            end
                            else
                            begin
                                fin = 1'b1;
                            end
                        end
                    end
                end
                hmf_pkg::PH_LENGTH, hmf_pkg::PH_CHUNK_DATA:
                begin
                    if (remaining_reg <= RW'(1))
                    begin
                        remaining_next = '0;
                        if (phase_reg == hmf_pkg::PH_LENGTH)
                        begin
                            fin = 1'b1;
                            phase_next = hmf_pkg::PH_HEADER;
                        end
                        else
                        begin
                            phase_next = hmf_pkg::PH_CHUNK_LINE;
                            line_count_next = 12'd0;
                            value_stage_next = hmf_pkg::V_LEAD;
                            number_acc_next = '0;
                            size_overflow_next = 1'b0;
                        end
                    end
                    else
                    begin
                        remaining_next = remaining_reg - RW'(1);
                    end
                end
                hmf_pkg::PH_CHUNK_LINE:
                begin
                    if (crlf && line_count_reg != 12'd0)
                    begin
                        if (value_stage_reg == hmf_pkg::V_LEAD
                            || value_stage_reg == hmf_pkg::V_BAD)
                        begin
                            err = hmf_pkg::ERR_BAD_CHUNK;
                        end
                        else if (size_overflow_reg)
                        begin
                            err = hmf_pkg::ERR_CHUNK_OVF;
                        end
                        else
                        begin
                            if (number_acc_reg == '0)
                            begin
                                phase_next = hmf_pkg::PH_TRAILER;
                            end
                            else
                            begin
                                remaining_next = {2'd0, number_acc_reg} + RW'(2);
                                phase_next = hmf_pkg::PH_CHUNK_DATA;
                            end
                            line_count_next = 12'd0;
                            value_stage_next = hmf_pkg::V_LEAD;
                            number_acc_next = '0;
                            size_overflow_next = 1'b0;
                        end
                    end
                    else if (line_count_reg >= cfg.chunk_line_cap)
                    begin
                        err = hmf_pkg::ERR_CHUNK_LONG;
                    end
                    else
                    begin
                        line_count_next = line_count_reg + 12'd1;
                        if (value_stage_reg == hmf_pkg::V_LEAD)
                        begin
                            if (hex[4])
                            begin
                                number_acc_next = {{(NW-4){1'b0}}, hex[3:0]};
                                value_stage_next = hmf_pkg::V_DIGITS;
                            end
                            else
                            begin
                                value_stage_next = hmf_pkg::V_BAD;
                            end
                        end
                        else if (value_stage_reg == hmf_pkg::V_DIGITS)
                        begin
                            if (!hex[4])
                            begin
                                value_stage_next = hmf_pkg::V_TRAIL;
                            end
                            else if (number_acc_reg[NW-1:NW-4] != 4'd0)
                            begin
                                size_overflow_next = 1'b1;
                            end
                            else
                            begin
                                number_acc_next = {number_acc_reg[NW-5:0], hex[3:0]};
                            end
                        end
                    end
                end
                hmf_pkg::PH_TRAILER:
                begin
                    if (crlf && line_count_reg != 12'd0)
                    begin
                        if (line_count_reg == 12'd1)
                        begin
                            fin = 1'b1;
                            phase_next = hmf_pkg::PH_HEADER;
                        end
                        line_count_next = 12'd0;
                    end
                    else if (line_count_reg >= cfg.trailer_line_cap)
                    begin
                        err = hmf_pkg::ERR_TRAILER_LONG;
                    end
                    else
                    begin
                        line_count_next = line_count_reg + 12'd1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (err != hmf_pkg::ERR_NONE)
            begin
                phase_next = phase_reg;
                sticky_error_next = err;
                hd = 1'b0;
                fin = 1'b0;
                mode = hmf_pkg::MODE_NONE;
            end
            else
            begin
                recent_bytes_next = {recent_bytes_reg[15:0], data_byte};
                if (fin)
                begin
                    recent_bytes_next = 24'd0;
                    clear_hdr = 1'b1;
                end
                if (clear_hdr)
                begin
                    header_count_next = 16'd0;
                    first_line_next = 1'b1;
                    line_kind_next = hmf_pkg::K_START;
                    name_match_pos_next = 5'd0;
                    chunked_match_pos_next = 3'd0;
                    have_length_next = 1'b0;
                    length_value_next = '0;
                    chunked_flag_next = 1'b0;
                    status_acc_next = 10'd0;
                    status_stage_next = 2'd0;
                    line_count_next = 12'd0;
                    value_stage_next = hmf_pkg::V_LEAD;
                    number_acc_next = '0;
                    size_overflow_next = 1'b0;
                end
            end
        end

        res.out_byte = data_byte;
        res.byte_class = hmf_pkg::phase_class(phase_reg);
        res.header_done = hd;
        res.body_mode = hd ? mode : hmf_pkg::MODE_NONE;
        res.message_end = fin;
        res.error_code = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= hmf_pkg::PH_HEADER;
            header_count_reg <= 16'd0;
            line_count_reg <= 12'd0;
            recent_bytes_reg <= 24'd0;
            first_line_reg <= 1'b1;
            line_kind_reg <= hmf_pkg::K_START;
            name_match_pos_reg <= 5'd0;
            value_stage_reg <= hmf_pkg::V_LEAD;
            number_acc_reg <= '0;
            length_value_reg <= '0;
            have_length_reg <= 1'b0;
            chunked_flag_reg <= 1'b0;
            chunked_match_pos_reg <= 3'd0;
            status_acc_reg <= 10'd0;
            status_stage_reg <= 2'd0;
            size_overflow_reg <= 1'b0;
            remaining_reg <= '0;
            sticky_error_reg <= hmf_pkg::ERR_NONE;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            header_count_reg <= header_count_next;
            line_count_reg <= line_count_next;
            recent_bytes_reg <= recent_bytes_next;
            first_line_reg <= first_line_next;
            line_kind_reg <= line_kind_next;
            name_match_pos_reg <= name_match_pos_next;
            value_stage_reg <= value_stage_next;
            number_acc_reg <= number_acc_next;
            length_value_reg <= length_value_next;
            have_length_reg <= have_length_next;
            chunked_flag_reg <= chunked_flag_next;
            chunked_match_pos_reg <= chunked_match_pos_next;
            status_acc_reg <= status_acc_next;
            status_stage_reg <= status_stage_next;
            size_overflow_reg <= size_overflow_next;
            remaining_reg <= remaining_next;
            sticky_error_reg <= sticky_error_next;
        end
    end

    // A raised error freezes the parser for good.
    `HMF_ASSERT(a_sticky_holds, clk, rst_n, (sticky_error_reg != hmf_pkg::ERR_NONE) |=> $stable(sticky_error_reg) && $stable(phase_reg))
    `HMF_ASSERT(a_done_in_header, clk, rst_n, (fire && res.header_done) |=> (recent_bytes_reg == 24'd0 || phase_reg != hmf_pkg::PH_HEADER || $past(res.message_end) == 1'b0))
    `HMF_ASSERT_NEVER(a_end_with_error, clk, rst_n, fire && res.message_end && res.error_code != hmf_pkg::ERR_NONE)

endmodule

// ----- hw/rtl/http_message_framer_unit.sv -----
// Top level of the HTTP/1.1 message framer: handshakes and the result register.
// Depends on hmf_pkg, hmf_cfg_regs and hmf_parser.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    data_byte
//   result    out        out_valid / out_stall  out_byte .. error_code
//   config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is accepted per cycle while in_stall is low, limited by the
// single parser state update. The result is registered and appears in the cycle after its transfer.
// Reset returns the parser to the header phase and the registers to defaults.
// A stalled result holds the result register; a new byte is taken while the
// held result is being transferred out.
`timescale 1ns / 1ps
module http_message_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic [2:0]  byte_class,
    output logic        header_done,
    output logic [1:0]  body_mode,
    output logic        message_end,
    output logic [2:0]  error_code,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    hmf_pkg::cfg_t cfg;
    hmf_pkg::result_t res;
    hmf_pkg::result_t res_reg;
    logic out_valid_reg;
    logic fire;

    assign in_stall = out_valid_reg && out_stall;
    assign fire = in_valid && !in_stall;

    hmf_cfg_regs u_cfg (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .cfg(cfg)
    );

    hmf_parser u_parser (
        .clk(clk),
        .rst_n(rst_n),
        .fire(fire),
        .data_byte(data_byte),
        .cfg(cfg),
        .res(res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte = res_reg.out_byte;
    assign byte_class = res_reg.byte_class;
    assign header_done = res_reg.header_done;
    assign body_mode = res_reg.body_mode;
    assign message_end = res_reg.message_end;
    assign error_code = res_reg.error_code;

endmodule

// ----- tb/sv/tb_http_message_framer_unit.sv -----
// Self-checking testbench for the HTTP/1.1 message framer top level.
// Depends on hmf_pkg and http_message_framer_unit; drives byte streams and
// checks every result transfer against a built-in framing predictor.
`timescale 1ns / 1ps
module tb_http_message_framer_unit;
    import hmf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam string CL_NAME = "content-length:";
    localparam string TE_NAME = "transfer-encoding:";
    localparam string CK_WORD = "chunked";

    typedef struct {
        string      text;
        bit         resp;
        bit         typed;
        logic [2:0] cls;
        logic       hd;
        logic [1:0] mode;
        logic       fin;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte;
    logic [2:0]  byte_class;
    logic        header_done;
    logic [1:0]  body_mode;
    logic        message_end;
    logic [2:0]  error_code;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;

    http_message_framer_unit dut (.*);

    // Register mirror and framing state of the predictor.
    logic         m_is_resp;
    logic [15:0]  m_hdr_cap;
    logic [11:0]  m_chunk_cap;
    logic [11:0]  m_trl_cap;
    logic [2:0]   f_phase;
    logic [15:0]  f_hdr_count;
    logic [11:0]  f_line_count;
    logic [23:0]  f_recent;
    logic         f_first_line;
    line_kind_t   f_kind;
    logic [4:0]   f_name_pos;
    value_stage_t f_stage;
    logic [63:0]  f_acc;
    logic [63:0]  f_length;
    logic         f_have_length;
    logic         f_chunked;
    logic [2:0]   f_ck_pos;
    logic [9:0]   f_status;
    logic [1:0]   f_status_stage;
    logic         f_size_ovf;
    logic [63:0]  f_remaining;
    logic [2:0]   f_sticky;

    result_t    expected_results[$];
    logic [7:0] msg_q[$];
    dir_row_t   dir_rows[$];
    int         mismatch_count;
    int         idle_cycles;
    int         send_idle_pct;
    int         stall_pct;

    function automatic logic [7:0] lower_case(input logic [7:0] b);
        return (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SP || b == CH_TAB;
    endfunction

    function automatic bit is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic int hex_value(input logic [7:0] b);
        logic [7:0] l;
        l = lower_case(b);
        if (is_digit(b))
        begin
            return b - 8'h30;
        end
        if (l >= "a" && l <= "f")
        begin
            return l - 8'h57;
        end
        return -1;
    endfunction

    function automatic void clear_line();
        f_line_count = '0;
        f_stage = V_LEAD;
        f_acc = '0;
        f_size_ovf = 1'b0;
    endfunction

    function automatic void clear_header();
        f_hdr_count = '0;
        f_first_line = 1'b1;
        f_kind = K_START;
        f_name_pos = '0;
        f_ck_pos = '0;
        f_have_length = 1'b0;
        f_length = '0;
        f_chunked = 1'b0;
        f_status = '0;
        f_status_stage = '0;
        clear_line();
    endfunction

    function automatic void framer_reset();
        m_is_resp = 1'b0;
        m_hdr_cap = 16'd8192;
        m_chunk_cap = 12'd256;
        m_trl_cap = 12'd1024;
        f_phase = CLS_HEADER;
        f_recent = '0;
        f_remaining = '0;
        f_sticky = ERR_NONE;
        clear_header();
    endfunction

    function automatic void status_step(input logic [7:0] b);
        int v;
        case (f_status_stage)
            2'd0:
            begin
                if (b == CH_SP) f_status_stage = 2'd1;
            end
            2'd1:
            begin
                if (is_digit(b))
                begin
                    f_status = 10'(b - 8'h30);
                    f_status_stage = 2'd2;
                end
                else if (!is_blank(b))
                begin
                    f_status = '0;
                    f_status_stage = 2'd3;
                end
            end
            2'd2:
            begin
                if (is_digit(b))
                begin
                    v = int'(f_status) * 10 + int'(b - 8'h30);
                    f_status = (v > 999) ? 10'd1000 : 10'(v);
                end
                else
                begin
                    f_status_stage = 2'd3;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void length_value_step(input logic [7:0] b, input logic [7:0] prev);
        logic [63:0] top;
        logic [63:0] d;
        top = (64'd1 << LENGTH_BITS) - 64'd1;
        if (prev == CH_CR) f_stage = V_BAD;
        if (b == CH_CR || f_stage == V_BAD) return;
        if (is_digit(b) && f_stage != V_TRAIL)
        begin
            d = 64'(b - 8'h30);
            if (f_stage == V_LEAD) f_acc = '0;
            if (f_acc > (top - d) / 64'd10)
            begin
                f_stage = V_BAD;
                return;
            end
            f_acc = f_acc * 64'd10 + d;
            f_stage = V_DIGITS;
        end
        else if (is_blank(b))
        begin
            if (f_stage == V_DIGITS) f_stage = V_TRAIL;
        end
        else
        begin
            f_stage = V_BAD;
        end
    endfunction

    function automatic void header_line_step(input logic [7:0] b, input logic [7:0] prev);
        logic [7:0] l;
        l = lower_case(b);
        if (f_first_line) status_step(b);
        case (f_kind)
            K_START:
            begin
                if (l == "c")
                begin
                    f_kind = K_MATCH_CL;
                    f_name_pos = 5'd1;
                end
                else if (l == "t")
                begin
                    f_kind = K_MATCH_TE;
                    f_name_pos = 5'd1;
                end
                else
                begin
                    f_kind = K_SKIP;
                end
            end
            K_MATCH_CL:
            begin
                if (f_name_pos < CL_NAME_LEN && l == CL_NAME[f_name_pos])
                begin
                    f_name_pos++;
                    if (f_name_pos == CL_NAME_LEN)
                    begin
                        f_kind = K_VAL_CL;
                        f_stage = V_LEAD;
                        f_acc = '0;
                    end
                end
                else
                begin
                    f_kind = K_SKIP;
                end
            end
            K_MATCH_TE:
            begin
                if (f_name_pos < TE_NAME_LEN && l == TE_NAME[f_name_pos])
                begin
                    f_name_pos++;
                    if (f_name_pos == TE_NAME_LEN)
                    begin
                        f_kind = K_VAL_TE;
                        f_ck_pos = '0;
                    end
                end
                else
                begin
                    f_kind = K_SKIP;
                end
            end
            K_VAL_CL: length_value_step(b, prev);
            K_VAL_TE:
            begin
                if (f_ck_pos < CK_WORD_LEN)
                begin
                    if (l == CK_WORD[f_ck_pos]) f_ck_pos++;
                    else f_ck_pos = (l == "c") ? 3'd1 : 3'd0;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [2:0] header_step(input logic [7:0] b, output logic hd,
                                               output logic [1:0] mode, output logic fin);
        logic [7:0] prev;
        bit         eol;
        bit         term;
        bit         forbids;
        prev = f_recent[7:0];
        eol = (b == CH_LF) && (prev == CH_CR);
        term = eol && (f_recent == TERM_PREFIX);
        hd = 1'b0;
        mode = MODE_NONE;
        fin = 1'b0;
        if (f_hdr_count >= m_hdr_cap) return ERR_HEADER_LONG;
        f_hdr_count++;
        if (!eol)
        begin
            header_line_step(b, prev);
            return ERR_NONE;
        end
        if (f_kind == K_VAL_CL)
        begin
            if (f_stage == V_LEAD || f_stage == V_BAD) return ERR_BAD_LENGTH;
            if (f_have_length && f_acc != f_length) return ERR_CONFLICT;
            f_length = f_acc;
            f_have_length = 1'b1;
        end
        else if (f_kind == K_VAL_TE)
        begin
            f_chunked = (f_ck_pos == CK_WORD_LEN);
        end
        f_kind = K_START;
        f_name_pos = '0;
        f_first_line = 1'b0;
        f_stage = V_LEAD;
        f_acc = '0;
        if (!term) return ERR_NONE;
        forbids = m_is_resp && ((f_status >= 100 && f_status < 200) || f_status == 204
                                || f_status == 304);
        hd = 1'b1;
        if (forbids)
        begin
            fin = 1'b1;
        end
        else if (f_chunked)
        begin
            mode = MODE_CHUNKED;
            f_phase = CLS_CHUNK_LINE;
        end
        else if (f_have_length && f_length > 0)
        begin
            mode = MODE_LENGTH;
            f_phase = CLS_LENGTH;
            f_remaining = f_length;
        end
        else if (m_is_resp && !f_have_length)
        begin
            mode = MODE_CLOSE;
            f_phase = CLS_CLOSE;
        end
        else
        begin
            fin = 1'b1;
        end
        clear_header();
        return ERR_NONE;
    endfunction

    function automatic logic [2:0] chunk_line_done();
        if (f_stage == V_LEAD || f_stage == V_BAD) return ERR_BAD_CHUNK;
        if (f_size_ovf) return ERR_CHUNK_OVF;
        if (f_acc == 0)
        begin
            f_phase = CLS_TRAILER;
        end
        else
        begin
            f_remaining = f_acc + 64'd2;
            f_phase = CLS_CHUNK_DATA;
        end
        clear_line();
        return ERR_NONE;
    endfunction

    function automatic void chunk_size_step(input logic [7:0] b);
        int h;
        h = hex_value(b);
        if (f_stage == V_LEAD)
        begin
            if (h >= 0)
            begin
                f_acc = 64'(h);
                f_stage = V_DIGITS;
            end
            else
            begin
                f_stage = V_BAD;
            end
        end
        else if (f_stage == V_DIGITS)
        begin
            if (h < 0) f_stage = V_TRAIL;
            else if ((f_acc >> (LENGTH_BITS - 4)) != 0) f_size_ovf = 1'b1;
            else f_acc = (f_acc << 4) | 64'(h);
        end
    endfunction

    function automatic result_t frame_byte(input logic [7:0] b);
        result_t    r;
        logic [2:0] cls;
        logic [2:0] err;
        logic       hd;
        logic [1:0] mode;
        logic       fin;
        bit         crlf;
        cls = f_phase;
        err = ERR_NONE;
        hd = 1'b0;
        mode = MODE_NONE;
        fin = 1'b0;
        crlf = (b == CH_LF) && (f_recent[7:0] == CH_CR);
        if (f_sticky != ERR_NONE)
        begin
            err = f_sticky;
        end
        else
        begin
            case (f_phase)
                CLS_HEADER: err = header_step(b, hd, mode, fin);
                CLS_LENGTH, CLS_CHUNK_DATA:
                begin
                    if (f_remaining <= 1)
                    begin
                        f_remaining = '0;
                        if (f_phase == CLS_LENGTH)
                        begin
                            fin = 1'b1;
                            f_phase = CLS_HEADER;
                        end
                        else
                        begin
                            f_phase = CLS_CHUNK_LINE;
                            clear_line();
                        end
                    end
                    else
                    begin
                        f_remaining--;
                    end
                end
                CLS_CHUNK_LINE:
                begin
                    if (crlf && f_line_count > 0) err = chunk_line_done();
                    else if (f_line_count >= m_chunk_cap) err = ERR_CHUNK_LONG;
                    else
                    begin
                        f_line_count++;
                        chunk_size_step(b);
                    end
                end
                CLS_TRAILER:
                begin
                    if (crlf && f_line_count > 0)
                    begin
                        if (f_line_count == 1)
                        begin
                            fin = 1'b1;
                            f_phase = CLS_HEADER;
                        end
                        f_line_count = '0;
                    end
                    else if (f_line_count >= m_trl_cap) err = ERR_TRAILER_LONG;
                    else f_line_count++;
                end
                default: ;
            endcase
            if (err != ERR_NONE)
            begin
                f_sticky = err;
                hd = 1'b0;
                fin = 1'b0;
            end
            else
            begin
                f_recent = {f_recent[15:0], b};
                if (fin)
                begin
                    f_recent = '0;
                    clear_header();
                end
            end
        end
        r.out_byte = b;
        r.byte_class = cls;
        r.header_done = hd;
        r.body_mode = hd ? mode : MODE_NONE;
        r.message_end = fin;
        r.error_code = err;
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
            if (out_valid && !out_stall)
            begin
                got.out_byte = out_byte;
                got.byte_class = byte_class;
                got.header_done = header_done;
                got.body_mode = body_mode;
                got.message_end = message_end;
                got.error_code = error_code;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: %h", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("mismatch: byte %h/%h class %0d/%0d done %b/%b mode %0d/%0d end %b/%b err %0d/%0d (exp/got)",
                                     want.out_byte, got.out_byte, want.byte_class, got.byte_class,
                                     want.header_done, got.header_done, want.body_mode,
                                     got.body_mode, want.message_end, got.message_end,
                                     want.error_code, got.error_code);
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit typed, input result_t typed_exp);
        result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk) in_valid <= 1'b0;
            repeat ($urandom_range(2)) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        r = frame_byte(b);
        expected_results.push_back(typed ? typed_exp : r);
    endtask

    task automatic send_message();
        result_t none;
        none = '0;
        foreach (msg_q[i]) send_byte(msg_q[i], 1'b0, none);
    endtask

    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        @(negedge clk) in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_IS_RESPONSE: m_is_resp = val[0];
            CFG_HEADER_CAP: m_hdr_cap = val;
            CFG_CHUNK_CAP: m_chunk_cap = val[11:0];
            CFG_TRAILER_CAP: m_trl_cap = val[11:0];
            default: ;
        endcase
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] any_text_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_CR || b == CH_LF);
        return b;
    endfunction

    function automatic void put(input string s);
        foreach (s[i]) msg_q.push_back(s[i]);
    endfunction

    function automatic void put_mixed_case(input string s);
        foreach (s[i])
        begin
            if (s[i] >= "a" && s[i] <= "z" && $urandom_range(1)) msg_q.push_back(s[i] - 8'd32);
            else msg_q.push_back(s[i]);
        end
    endfunction

    function automatic void put_blanks();
        repeat ($urandom_range(2)) msg_q.push_back($urandom_range(1) ? CH_SP : CH_TAB);
    endfunction

    function automatic void put_length_line(input int n);
        put_mixed_case("content-length:");
        put_blanks();
        if ($urandom_range(3) == 0) put("00");
        put($sformatf("%0d", n));
        put_blanks();
        put("\015\012");
    endfunction

    function automatic void build_message(input bit resp);
        int  st;
        int  kind;
        int  n;
        int  sz;
        bit  forbids;
        msg_q.delete();
        forbids = 1'b0;
        if (resp)
        begin
            case ($urandom_range(6))
                0: st = 200;
                1: st = 204;
                2: st = 304;
                3: st = 100 + $urandom_range(99);
                4: st = 404;
                5: st = 99999;
                default: st = $urandom_range(999);
            endcase
            forbids = (st >= 100 && st < 200) || st == 204 || st == 304;
            put("HTTP/1.1 ");
            if ($urandom_range(3) == 0) put(" ");
            put($sformatf("%0d", st));
            put(" OK\015\012");
        end
        else
        begin
            put("GET /x HTTP/1.1\015\012");
        end
        repeat ($urandom_range(2))
        begin
            put("X-");
            repeat ($urandom_range(1, 6)) msg_q.push_back(any_text_byte());
            put("\015\012");
        end
        kind = $urandom_range(3);
        n = $urandom_range(8);
        if (kind == 0 && resp) put_length_line(0);
        if (kind == 1 || kind == 3)
        begin
            put_length_line(n);
            if ($urandom_range(3) == 0) put_length_line(n);
        end
        if (kind >= 2)
        begin
            put_mixed_case("transfer-encoding:");
            put(" ");
            if ($urandom_range(1)) put("gzip, ");
            put_mixed_case("chunked");
            put("\015\012");
        end
        else if (kind == 1 && $urandom_range(3) == 0)
        begin
            put("Transfer-Encoding: gzip\015\012");
        end
        put("\015\012");
        if (forbids) return;
        if (kind >= 2)
        begin
            repeat ($urandom_range(3))
            begin
                sz = $urandom_range(1, 12);
                put_mixed_case($sformatf("%0h", sz));
                if ($urandom_range(2) == 0) put(";ext=1");
                put("\015\012");
                repeat (sz) msg_q.push_back(8'($urandom));
                put("\015\012");
            end
            put("0\015\012");
            repeat ($urandom_range(2)) put("T: v\015\012");
            put("\015\012");
        end
        else if (kind == 1)
        begin
            repeat (n) msg_q.push_back(8'($urandom));
        end
    endfunction

    function automatic void add_row(input string text, input bit resp, input bit typed,
                                    input logic [2:0] cls, input logic hd,
                                    input logic [1:0] mode, input logic fin);
        dir_row_t row;
        row.text = text;
        row.resp = resp;
        row.typed = typed;
        row.cls = cls;
        row.hd = hd;
        row.mode = mode;
        row.fin = fin;
        dir_rows.push_back(row);
    endfunction

    task automatic run_directed();
        result_t exp_last;
        bit      last;
        add_row("GET / HTTP/1.1\015\012\015\012", 0, 1, CLS_HEADER, 1, MODE_NONE, 1);
        add_row("POST / HTTP/1.1\015\012Content-Length: 3\015\012\015\012", 0, 1,
                CLS_HEADER, 1, MODE_LENGTH, 0);
        add_row("abc", 0, 1, CLS_LENGTH, 0, MODE_NONE, 1);
        add_row("PUT / HTTP/1.1\015\012transfer-encoding: gzip, chunked\015\012\015\012", 0, 1,
                CLS_HEADER, 1, MODE_CHUNKED, 0);
        add_row("A;x=y\015\0120123456789\015\0120\015\012T: 1\015\012\015\012", 0, 1,
                CLS_TRAILER, 0, MODE_NONE, 1);
        add_row("X / HTTP/1.1\015\012CONTENT-LENGTH:\t0 \015\012\015\012", 0, 1,
                CLS_HEADER, 1, MODE_NONE, 1);
        add_row("Z: \001\377\200\177\015\012\015\012", 0, 1, CLS_HEADER, 1, MODE_NONE, 1);
        add_row("HTTP/1.1 204 No\015\012Content-Length: 5\015\012\015\012", 1, 1,
                CLS_HEADER, 1, MODE_NONE, 1);
        add_row("HTTP/1.1 100 Go\015\012\015\012", 1, 1, CLS_HEADER, 1, MODE_NONE, 1);
        add_row("HTTP/1.1 304 NM\015\012Transfer-Encoding: chunked\015\012\015\012", 1, 1,
                CLS_HEADER, 1, MODE_NONE, 1);
        add_row("HTTP/1.1 200 OK\015\012Content-Length: 2\015\012\015\012hi", 1, 1,
                CLS_LENGTH, 0, MODE_NONE, 1);
        add_row("HTTP/1.1 +99 X\015\012Content-Length: 1\015\012\015\012z", 1, 0,
                CLS_LENGTH, 0, MODE_NONE, 1);
        add_row("HTTP/1.1  99999 X\015\012content-length: 4294967295 \015\012Content-Length: 1\015\012\015\012", 1, 0,
                CLS_HEADER, 0, MODE_NONE, 0);
        add_row("HTTP/1.1 199 E\015\012Content-Length: 1\015\012\015\012", 1, 0,
                CLS_HEADER, 1, MODE_NONE, 1);
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].resp != m_is_resp) write_reg(CFG_IS_RESPONSE, 16'(dir_rows[k].resp));
            msg_q.delete();
            put(dir_rows[k].text);
            foreach (msg_q[i])
            begin
                last = (i == msg_q.size() - 1) && dir_rows[k].typed;
                exp_last.out_byte = msg_q[i];
                exp_last.byte_class = dir_rows[k].cls;
                exp_last.header_done = dir_rows[k].hd;
                exp_last.body_mode = dir_rows[k].mode;
                exp_last.message_end = dir_rows[k].fin;
                exp_last.error_code = ERR_NONE;
                send_byte(msg_q[i], last, exp_last);
            end
        end
    endtask

    // The run ends with one fault or an endless close body, since both freeze
    // the framer until the next reset.
    task automatic run_final_fault();
        result_t none;
        none = '0;
        msg_q.delete();
        case ($urandom_range(7))
            0:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd0);
                put("GET / HTTP/1.1\015\012Content-Length: ");
                put($urandom_range(1) ? "1x" : "4294967296");
                put("\015\012\015\012");
            end
            1:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd0);
                put("GET / HTTP/1.1\015\012Content-Length: 3\015\012Content-Length: 4\015\012\015\012");
            end
            2:
            begin
                write_reg(CFG_HEADER_CAP, 16'd16);
                put("GET /long/path HTTP/1.1\015\012\015\012");
            end
            3:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd0);
                write_reg(CFG_CHUNK_CAP, 16'd1);
                put("GET / HTTP/1.1\015\012Transfer-Encoding: chunked\015\012\015\0125\015\012");
            end
            4:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd0);
                put("GET / HTTP/1.1\015\012Transfer-Encoding: chunked\015\012\015\012zz\015\012");
            end
            5:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd0);
                put("GET / HTTP/1.1\015\012Transfer-Encoding: chunked\015\012\015\0121ffffffff\015\012");
            end
            6:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd0);
                write_reg(CFG_TRAILER_CAP, 16'd1);
                put("GET / HTTP/1.1\015\012Transfer-Encoding: chunked\015\012\015\0120\015\012TT: v\015\012");
            end
            default:
            begin
                write_reg(CFG_IS_RESPONSE, 16'd1);
                put("HTTP/1.1 200 OK\015\012\015\012");
            end
        endcase
        repeat (20) msg_q.push_back(8'($urandom));
        send_message();
    endtask

    initial
    begin
        int send_pcts[4];
        int stall_pcts[4];
        int sent;
        bit resp;
        send_pcts = '{0, 48, 0, 15};
        stall_pcts = '{0, 0, 48, 15};
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_idle_pct = 15;
        stall_pct = 15;
        framer_reset();
        repeat (9) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            stall_pct = stall_pcts[p];
            resp = $urandom_range(1);
            write_reg(CFG_IS_RESPONSE, 16'(resp));
            write_reg(CFG_HEADER_CAP, (p == 0) ? 16'd65535 : 16'($urandom_range(400, 65535)));
            write_reg(CFG_CHUNK_CAP, (p == 0) ? 16'd4095 : 16'($urandom_range(24, 4095)));
            write_reg(CFG_TRAILER_CAP, (p == 0) ? 16'd4095 : 16'($urandom_range(24, 4095)));
            sent = 0;
            while (sent < 125)
            begin
                build_message(resp);
                sent += msg_q.size();
                send_message();
            end
        end

        run_final_fault();

        @(negedge clk) in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/hmf_pkg.sv
hw/rtl/hmf_cfg_regs.sv
hw/rtl/hmf_parser.sv
hw/rtl/http_message_framer_unit.sv
tb/sv/tb_http_message_framer_unit.sv
